### src/vna_pkg.sv
// Shared constants and types for the vertex normal accumulator.
package vna_pkg;

  localparam int VERTEX_DEPTH = 1024;
  localparam int SUM_WIDTH    = 48;
  localparam int IDX_W        = $clog2(VERTEX_DEPTH);
  localparam int CROSS_W      = 36;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_TRI   = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef struct packed {
    logic signed [SUM_WIDTH-1:0] x;
    logic signed [SUM_WIDTH-1:0] y;
    logic signed [SUM_WIDTH-1:0] z;
  } sum3_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } norm3_t;

endpackage

### src/vna_if.sv
// Handshake channels for commands in and normals out.
interface vna_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  cmd;
  logic        [9:0]  vertex_a;
  logic        [9:0]  vertex_b;
  logic        [9:0]  vertex_c;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;

  modport source (output valid, cmd, vertex_a, vertex_b, vertex_c, pos_x, pos_y, pos_z,
                  input ready);
  modport sink   (input valid, cmd, vertex_a, vertex_b, vertex_c, pos_x, pos_y, pos_z,
                  output ready);
endinterface

interface vna_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;

  modport source (output valid, normal_x, normal_y, normal_z, input ready);
  modport sink   (input valid, normal_x, normal_y, normal_z, output ready);
endinterface

### src/vna_ram.sv
// Generic RAM, one write port, one registered read port.
module vna_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/vna_norm.sv
// Iterative normalizer: common shift, sum of squares, square root, three divides.
module vna_norm import vna_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,
  input  sum3_t  sum_i,
  output logic   done_o,
  output norm3_t norm_o
);

  typedef enum logic [2:0] {N_IDLE, N_SHIFT, N_SQ, N_SQRT, N_DLOAD, N_DIV} state_e;

  state_e               state_q;
  logic [SUM_WIDTH-1:0] a_q [3];
  logic                 neg_q [3];
  logic [61:0]          rem_q, res_q;
  logic [4:0]           j_q;
  logic [1:0]           cnt_q;
  logic [30:0]          r_q;
  logic [45:0]          drem_q;
  logic [3:0]           i_q;
  logic [14:0]          qt_q;
  norm3_t               out_q;
  logic                 done_q;

  logic [SUM_WIDTH-1:0] m, mag [3];
  logic signed [SUM_WIDTH-1:0] s_in [3];
  logic [59:0]          sq;
  logic [61:0]          bitv, tv, rem_nx, res_nx;
  logic [45:0]          dv, drem_nx;
  logic [14:0]          qt_nx;
  logic signed [15:0]   comp;

  always_comb begin
    s_in[0] = sum_i.x;
    s_in[1] = sum_i.y;
    s_in[2] = sum_i.z;
    for (int k = 0; k < 3; k++) begin
      mag[k] = s_in[k][SUM_WIDTH-1] ? SUM_WIDTH'(-s_in[k]) : SUM_WIDTH'(s_in[k]);
    end
    m = a_q[0];
    if (a_q[1] > m) m = a_q[1];
    if (a_q[2] > m) m = a_q[2];
    sq   = a_q[cnt_q][29:0] * a_q[cnt_q][29:0];
    bitv = 62'(1) << {j_q, 1'b0};
    tv   = res_q + bitv;
    if (rem_q >= tv) begin
      rem_nx = rem_q - tv;
      res_nx = (res_q >> 1) + bitv;
    end else begin
      rem_nx = rem_q;
      res_nx = res_q >> 1;
    end
    dv = 46'(r_q) << i_q;
    drem_nx = drem_q;
    qt_nx   = qt_q;
    if (drem_q >= dv) begin
      drem_nx    = drem_q - dv;
      qt_nx[i_q] = 1'b1;
    end
    comp = neg_q[cnt_q] ? -$signed({1'b0, qt_nx}) : $signed({1'b0, qt_nx});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      j_q     <= '0;
      i_q     <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        N_IDLE: begin
          if (start_i) begin
            for (int k = 0; k < 3; k++) begin
              a_q[k]   <= mag[k];
              neg_q[k] <= s_in[k][SUM_WIDTH-1];
            end
            if (sum_i == '0) begin
              out_q  <= '0;
              done_q <= 1'b1;
            end else begin
              state_q <= N_SHIFT;
            end
          end
        end
        N_SHIFT: begin
          if (|m[SUM_WIDTH-1:30]) begin
            for (int k = 0; k < 3; k++) a_q[k] <= a_q[k] >> 1;
          end else if (!(|m[SUM_WIDTH-1:29])) begin
            for (int k = 0; k < 3; k++) a_q[k] <= a_q[k] << 1;
          end else begin
            cnt_q   <= '0;
            rem_q   <= '0;
            state_q <= N_SQ;
          end
        end
        N_SQ: begin
          rem_q <= rem_q + 62'(sq);
          if (cnt_q == 2'd2) begin
            res_q   <= '0;
            j_q     <= 5'd30;
            state_q <= N_SQRT;
          end else begin
            cnt_q <= cnt_q + 2'd1;
          end
        end
        N_SQRT: begin
          rem_q <= rem_nx;
          res_q <= res_nx;
          j_q   <= j_q - 5'd1;
          if (j_q == '0) begin
            r_q     <= res_nx[30:0];
            cnt_q   <= '0;
            state_q <= N_DLOAD;
          end
        end
        N_DLOAD: begin
          // rounded quotient: (a * 2^14 + r/2) / r
          drem_q  <= {2'b0, a_q[cnt_q][29:0], 14'b0} + 46'(r_q >> 1);
          qt_q    <= '0;
          i_q     <= 4'd14;
          state_q <= N_DIV;
        end
        N_DIV: begin
          drem_q <= drem_nx;
          qt_q   <= qt_nx;
          i_q    <= i_q - 4'd1;
          if (i_q == '0) begin
            case (cnt_q)
              2'd0:    out_q.x <= comp;
              2'd1:    out_q.y <= comp;
              default: out_q.z <= comp;
            endcase
            if (cnt_q == 2'd2) begin
              done_q  <= 1'b1;
              state_q <= N_IDLE;
            end else begin
              cnt_q   <= cnt_q + 2'd1;
              state_q <= N_DLOAD;
            end
          end
        end
        default: state_q <= N_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign norm_o = out_q;

endmodule

### src/vertex_normal_accumulator.sv
// Area-weighted vertex normal accumulator: top level.
// Vertex write: done in its transfer. Triangle: position reads of its 3 corners,
// 6 steps of one 17x17 multiplier, 3 read-modify-writes of the sums.
// Read: the one-bit-a-cycle normalizing shift (0 to 29 steps), the 31-step square root
// and three divides, plus any output stall; a zero sum skips the normalizer steps.
// One item is in work at a time. After reset a clearing pass zeroes the sum memory
// with input ready low.
module vertex_normal_accumulator import vna_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  vna_in_if.sink      in_i,
  vna_out_if.source   out_o
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_PRD, S_MUL, S_ACC_RD, S_ACC_WR, S_RRD, S_RDAT, S_NORM, S_DONE
  } state_e;

  state_e                    state_q;
  logic [IDX_W-1:0]          clr_q;
  logic [2:0]                cnt_q;
  logic [IDX_W-1:0]          idx_q [3];
  logic signed [15:0]        px_q [3], py_q [3], pz_q [3];
  logic signed [CROSS_W-1:0] c_q [3];
  norm3_t                    res_q, out_q;
  logic                      out_valid_q;

  logic                      accept, tri_ok;
  cmd_e                      cmd;
  logic [IDX_W-1:0]          idx_sel;
  logic                      pos_we, sum_we;
  logic [IDX_W-1:0]          sum_waddr, sum_raddr;
  logic [47:0]               pos_rdata;
  sum3_t                     sum_rdata, sum_wdata, sum_new;
  logic signed [16:0]        e0x, e0y, e0z, e1x, e1y, e1z, opa, opb;
  logic signed [33:0]        prod;
  logic                      norm_done;
  norm3_t                    norm_res;

  function automatic logic in_range(logic [9:0] v);
    return 32'(v) < VERTEX_DEPTH;
  endfunction

  function automatic logic signed [SUM_WIDTH-1:0] sat_add(
    logic signed [SUM_WIDTH-1:0] s, logic signed [CROSS_W-1:0] c);
    logic signed [SUM_WIDTH:0] t;
    t = (SUM_WIDTH+1)'(s) + (SUM_WIDTH+1)'(c);
    if (t[SUM_WIDTH] != t[SUM_WIDTH-1]) begin
      return t[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}} : {1'b0, {(SUM_WIDTH-1){1'b1}}};
    end
    return t[SUM_WIDTH-1:0];
  endfunction

  assign cmd    = cmd_e'(in_i.cmd);
  assign accept = in_i.valid && in_i.ready;
  assign tri_ok = in_range(in_i.vertex_a) && in_range(in_i.vertex_b) &&
                  in_range(in_i.vertex_c);
  assign in_i.ready = (state_q == S_IDLE);

  always_comb begin
    case (cnt_q)
      3'd0:    idx_sel = idx_q[0];
      3'd1:    idx_sel = idx_q[1];
      default: idx_sel = idx_q[2];
    endcase
  end

  // edge vectors and the shared multiplier
  assign e0x = 17'(px_q[1]) - 17'(px_q[0]);
  assign e0y = 17'(py_q[1]) - 17'(py_q[0]);
  assign e0z = 17'(pz_q[1]) - 17'(pz_q[0]);
  assign e1x = 17'(px_q[2]) - 17'(px_q[0]);
  assign e1y = 17'(py_q[2]) - 17'(py_q[0]);
  assign e1z = 17'(pz_q[2]) - 17'(pz_q[0]);

  always_comb begin
    case (cnt_q)
      3'd0:    begin opa = e0y; opb = e1z; end
      3'd1:    begin opa = e0z; opb = e1y; end
      3'd2:    begin opa = e0z; opb = e1x; end
      3'd3:    begin opa = e0x; opb = e1z; end
      3'd4:    begin opa = e0x; opb = e1y; end
      default: begin opa = e0y; opb = e1x; end
    endcase
  end
  assign prod = opa * opb;

  assign sum_new.x = sat_add(sum_rdata.x, c_q[0]);
  assign sum_new.y = sat_add(sum_rdata.y, c_q[1]);
  assign sum_new.z = sat_add(sum_rdata.z, c_q[2]);

  assign pos_we = accept && (cmd == CMD_WRITE) && in_range(in_i.vertex_a);

  always_comb begin
    sum_we    = 1'b0;
    sum_waddr = IDX_W'(in_i.vertex_a);
    sum_wdata = '0;
    sum_raddr = idx_q[0];
    unique case (state_q)
      S_CLEAR: begin
        sum_we    = 1'b1;
        sum_waddr = clr_q;
      end
      S_IDLE:   sum_we = pos_we;
      S_ACC_RD: sum_raddr = idx_sel;
      S_ACC_WR: begin
        sum_we    = 1'b1;
        sum_waddr = idx_sel;
        sum_wdata = sum_new;
      end
      default: ;
    endcase
  end

  vna_ram #(.WIDTH(48), .DEPTH(VERTEX_DEPTH)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (IDX_W'(in_i.vertex_a)),
    .wdata_i ({in_i.pos_x, in_i.pos_y, in_i.pos_z}),
    .raddr_i (idx_sel),
    .rdata_o (pos_rdata)
  );

  vna_ram #(.WIDTH(3*SUM_WIDTH), .DEPTH(VERTEX_DEPTH)) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (sum_waddr),
    .wdata_i (sum_wdata),
    .raddr_i (sum_raddr),
    .rdata_o (sum_rdata)
  );

  vna_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_RDAT),
    .sum_i   (sum_rdata),
    .done_o  (norm_done),
    .norm_o  (norm_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_DONE && (!out_valid_q || out_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + IDX_W'(1);
          if (clr_q == IDX_W'(VERTEX_DEPTH - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            idx_q[0] <= IDX_W'(in_i.vertex_a);
            idx_q[1] <= IDX_W'(in_i.vertex_b);
            idx_q[2] <= IDX_W'(in_i.vertex_c);
            cnt_q    <= '0;
            case (cmd)
              CMD_TRI: if (tri_ok) state_q <= S_PRD;
              CMD_READ: begin
                if (in_range(in_i.vertex_a)) begin
                  state_q <= S_RRD;
                end else begin
                  res_q   <= '0;
                  state_q <= S_DONE;
                end
              end
              default: ;
            endcase
          end
        end
        S_PRD: begin
          // read issued for corner cnt, data of corner cnt-1 lands now
          case (cnt_q)
            3'd1: {px_q[0], py_q[0], pz_q[0]} <= pos_rdata;
            3'd2: {px_q[1], py_q[1], pz_q[1]} <= pos_rdata;
            3'd3: {px_q[2], py_q[2], pz_q[2]} <= pos_rdata;
            default: ;
          endcase
          if (cnt_q == 3'd3) begin
            cnt_q   <= '0;
            state_q <= S_MUL;
          end else begin
            cnt_q <= cnt_q + 3'd1;
          end
        end
        S_MUL: begin
          if (!cnt_q[0]) c_q[cnt_q[2:1]] <= CROSS_W'(prod);
          else           c_q[cnt_q[2:1]] <= c_q[cnt_q[2:1]] - CROSS_W'(prod);
          if (cnt_q == 3'd5) begin
            cnt_q   <= '0;
            state_q <= S_ACC_RD;
          end else begin
            cnt_q <= cnt_q + 3'd1;
          end
        end
        S_ACC_RD: state_q <= S_ACC_WR;
        S_ACC_WR: begin
          if (cnt_q == 3'd2) begin
            state_q <= S_IDLE;
          end else begin
            cnt_q   <= cnt_q + 3'd1;
            state_q <= S_ACC_RD;
          end
        end
        S_RRD:  state_q <= S_RDAT;
        S_RDAT: state_q <= S_NORM;
        S_NORM: begin
          if (norm_done) begin
            res_q   <= norm_res;
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            out_q   <= res_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.normal_x = out_q.x;
  assign out_o.normal_y = out_q.y;
  assign out_o.normal_z = out_q.z;

`ifndef NO_ASSERTIONS
  a_sum_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_we |-> (state_q == S_CLEAR || state_q == S_IDLE || state_q == S_ACC_WR))
    else $error("sum memory written outside clear, vertex write or accumulate");
  a_norm_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    norm_done |-> state_q == S_NORM)
    else $error("normalizer finished with no read in progress");
  a_tri_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd == CMD_TRI && tri_ok) |=> state_q == S_PRD)
    else $error("triangle transfer did not start position reads");
  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.x <= 16'sd16384 && out_q.x >= -16'sd16384 &&
                     out_q.y <= 16'sd16384 && out_q.y >= -16'sd16384 &&
                     out_q.z <= 16'sd16384 && out_q.z >= -16'sd16384))
    else $error("normal component beyond unit range");
`endif

endmodule

### bench/vertex_normal_accumulator_test.sv
// Self-checking testbench for the vertex normal accumulator.
`timescale 1ns / 100ps

module vertex_normal_accumulator_test;
  import vna_pkg::*;

  localparam longint SUM_HI = (64'sd1 <<< (SUM_WIDTH - 1)) - 1;
  localparam longint SUM_LO = -SUM_HI - 1;
  localparam int     STALL_LIMIT = 5000;

  // Predicts vertex normals and holds the ones still owed by the block.
  class normal_scoreboard;
    logic signed [15:0] pos_x_mem [VERTEX_DEPTH];
    logic signed [15:0] pos_y_mem [VERTEX_DEPTH];
    logic signed [15:0] pos_z_mem [VERTEX_DEPTH];
    longint             sum_x_mem [VERTEX_DEPTH];
    longint             sum_y_mem [VERTEX_DEPTH];
    longint             sum_z_mem [VERTEX_DEPTH];
    norm3_t             owed_normals [$];
    int                 errors;

    function new();
      for (int i = 0; i < VERTEX_DEPTH; i++) begin
        pos_x_mem[i] = '0; pos_y_mem[i] = '0; pos_z_mem[i] = '0;
        sum_x_mem[i] = 0;  sum_y_mem[i] = 0;  sum_z_mem[i] = 0;
      end
      errors = 0;
    endfunction

    function longint sat_add(longint acc, longint inc);
      if (inc > 0 && acc > SUM_HI - inc) return SUM_HI;
      if (inc < 0 && acc < SUM_LO - inc) return SUM_LO;
      return acc + inc;
    endfunction

    function norm3_t unit_normal(int v);
      longint            s [3];
      longint unsigned   a [3];
      longint unsigned   m, n, r, bit_w, q;
      norm3_t            res;
      s[0] = sum_x_mem[v]; s[1] = sum_y_mem[v]; s[2] = sum_z_mem[v];
      m = 0;
      for (int i = 0; i < 3; i++) begin
        a[i] = (s[i] < 0) ? longint'(-s[i]) : longint'(s[i]);
        if (a[i] > m) m = a[i];
      end
      res = '0;
      if (m == 0) return res;
      while (m >= (64'd1 << 30)) begin
        m >>= 1;
        for (int i = 0; i < 3; i++) a[i] >>= 1;
      end
      while (m < (64'd1 << 29)) begin
        m <<= 1;
        for (int i = 0; i < 3; i++) a[i] <<= 1;
      end
      n = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
      // bitwise integer square root
      r = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > n) bit_w >>= 2;
      while (bit_w != 0) begin
        if (n >= r + bit_w) begin
          n -= r + bit_w;
          r = (r >> 1) + bit_w;
        end else begin
          r >>= 1;
        end
        bit_w >>= 2;
      end
      for (int i = 0; i < 3; i++) begin
        q = (a[i] * 16384 + r / 2) / r;
        if (s[i] < 0) q = -q;
        if (i == 0) res.x = q[15:0];
        else if (i == 1) res.y = q[15:0];
        else res.z = q[15:0];
      end
      return res;
    endfunction

    function void note_command(logic [1:0] cmd, int va, int vb, int vc,
                               logic signed [15:0] x, logic signed [15:0] y,
                               logic signed [15:0] z);
      longint e0x, e0y, e0z, e1x, e1y, e1z, cx, cy, cz;
      int     corner [3];
      if (cmd == CMD_WRITE) begin
        pos_x_mem[va] = x; pos_y_mem[va] = y; pos_z_mem[va] = z;
        sum_x_mem[va] = 0; sum_y_mem[va] = 0; sum_z_mem[va] = 0;
      end else if (cmd == CMD_TRI) begin
        e0x = longint'(pos_x_mem[vb]) - longint'(pos_x_mem[va]);
        e0y = longint'(pos_y_mem[vb]) - longint'(pos_y_mem[va]);
        e0z = longint'(pos_z_mem[vb]) - longint'(pos_z_mem[va]);
        e1x = longint'(pos_x_mem[vc]) - longint'(pos_x_mem[va]);
        e1y = longint'(pos_y_mem[vc]) - longint'(pos_y_mem[va]);
        e1z = longint'(pos_z_mem[vc]) - longint'(pos_z_mem[va]);
        cx = e0y * e1z - e0z * e1y;
        cy = e0z * e1x - e0x * e1z;
        cz = e0x * e1y - e0y * e1x;
        corner[0] = va; corner[1] = vb; corner[2] = vc;
        for (int k = 0; k < 3; k++) begin
          sum_x_mem[corner[k]] = sat_add(sum_x_mem[corner[k]], cx);
          sum_y_mem[corner[k]] = sat_add(sum_y_mem[corner[k]], cy);
          sum_z_mem[corner[k]] = sat_add(sum_z_mem[corner[k]], cz);
        end
      end else if (cmd == CMD_READ) begin
        owed_normals = {owed_normals, unit_normal(va)};
      end
    endfunction

    function void check_normal(norm3_t got);
      norm3_t exp_n;
      if (owed_normals.size() == 0) begin
        $display("%0t: normal with none expected: got %0d %0d %0d",
                 $time, got.x, got.y, got.z);
        errors++;
        return;
      end
      exp_n = owed_normals.pop_front();
      if (got.x !== exp_n.x) begin
        $display("%0t: normal_x expected %0d actual %0d", $time, exp_n.x, got.x);
        errors++;
      end
      if (got.y !== exp_n.y) begin
        $display("%0t: normal_y expected %0d actual %0d", $time, exp_n.y, got.y);
        errors++;
      end
      if (got.z !== exp_n.z) begin
        $display("%0t: normal_z expected %0d actual %0d", $time, exp_n.z, got.z);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  vna_in_if  in_ch ();
  vna_out_if out_ch ();

  vertex_normal_accumulator u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always #1 clk_i = ~clk_i;

  normal_scoreboard sb = new();

  bit in_gaps_on  = 1'b0;
  bit out_stall_on = 1'b0;
  int out_hold;
  int idle_cycles = 0;

  bit written [VERTEX_DEPTH];
  int written_list [$];

  // record every transfer on both channels
  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready)
      sb.note_command(in_ch.cmd, int'(in_ch.vertex_a), int'(in_ch.vertex_b),
                      int'(in_ch.vertex_c), in_ch.pos_x, in_ch.pos_y, in_ch.pos_z);
    if (rst_ni && out_ch.valid && out_ch.ready)
      sb.check_normal('{x: out_ch.normal_x, y: out_ch.normal_y, z: out_ch.normal_z});
  end

  // output back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      out_hold     <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      if (out_stall_on && $urandom_range(0, 4) != 0) begin
        out_hold     <= $urandom_range(1, 4);
        out_ch.ready <= 1'b0;
      end
    end else if (out_hold > 0) begin
      out_hold <= out_hold - 1;
      out_ch.ready <= (out_hold == 1);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL vertex_normal_accumulator");
      $finish;
    end
  end

  task automatic send_command(logic [1:0] cmd, int va, int vb, int vc,
                              logic [15:0] x, logic [15:0] y, logic [15:0] z);
    int gap;
    gap = in_gaps_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.cmd      <= cmd;
    in_ch.vertex_a <= va[9:0];
    in_ch.vertex_b <= vb[9:0];
    in_ch.vertex_c <= vc[9:0];
    in_ch.pos_x    <= x;
    in_ch.pos_y    <= y;
    in_ch.pos_z    <= z;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    if (cmd == CMD_WRITE && !written[va]) begin
      written[va] = 1'b1;
      written_list = {written_list, va};
    end
  endtask

  task automatic write_vertex(int v, logic [15:0] x, logic [15:0] y, logic [15:0] z);
    send_command(CMD_WRITE, v, $urandom_range(0, 1023), $urandom_range(0, 1023), x, y, z);
  endtask

  task automatic add_triangle(int va, int vb, int vc);
    send_command(CMD_TRI, va, vb, vc, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic read_normal(int v);
    send_command(CMD_READ, v, $urandom_range(0, 1023), $urandom_range(0, 1023),
                 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  function automatic int pick_written();
    return written_list[$urandom_range(0, written_list.size() - 1)];
  endfunction

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 3))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'(int'($urandom_range(0, 255)) - 128);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int op, base;
    in_ch.valid    = 1'b0;
    in_ch.cmd      = CMD_WRITE;
    in_ch.vertex_a = '0;
    in_ch.vertex_b = '0;
    in_ch.vertex_c = '0;
    in_ch.pos_x    = '0;
    in_ch.pos_y    = '0;
    in_ch.pos_z    = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extreme positions, all commands, corner cases
    write_vertex(1021, 16'sh8000, 16'sh8000, 16'sh8000);
    write_vertex(1022, 16'sh7fff, 16'sh8000, 16'sh7fff);
    write_vertex(1023, 16'sh8000, 16'sh7fff, 16'sh7fff);
    add_triangle(1021, 1022, 1023);
    read_normal(1021);
    read_normal(1023);
    add_triangle(1023, 1023, 1022);          // repeated corner
    read_normal(1022);
    read_normal(500);                        // sum still zero
    send_command(2'd3, 1021, 1022, 1023, 16'hffff, 16'hffff, 16'hffff);
    write_vertex(1021, 16'sh0100, 16'sh0000, 16'sh0000);
    read_normal(1021);                       // cleared by the rewrite
    write_vertex(10, 16'sh0000, 16'sh0000, 16'sh0000);
    write_vertex(11, 16'sh0001, 16'sh0000, 16'sh0000);
    write_vertex(12, 16'sh0000, 16'sh0001, 16'sh0000);
    add_triangle(10, 11, 12);
    read_normal(10);
    add_triangle(10, 12, 11);                // opposite winding cancels
    read_normal(11);

    // largest face normal, added a few times to build a large sum
    write_vertex(0, 16'sh8000, 16'sh8000, 16'sh0000);
    write_vertex(1, 16'sh7fff, 16'sh8000, 16'sh0000);
    write_vertex(2, 16'sh8000, 16'sh7fff, 16'sh0000);
    repeat (20) add_triangle(0, 1, 2);
    read_normal(0);
    read_normal(2);

    // random: mostly meshes built on written vertices
    for (int i = 0; i < 600; i++) begin
      if (i % 100 == 0) begin
        in_gaps_on   = $urandom_range(0, 3) != 0;
        out_stall_on = $urandom_range(0, 3) != 0;
      end
      op = $urandom_range(0, 99);
      if (op < 20) begin
        write_vertex($urandom_range(0, 2) == 0 ? $urandom_range(0, 1023)
                                               : $urandom_range(0, 31),
                     pick_coord(), pick_coord(), pick_coord());
      end else if (op < 65) begin
        if ($urandom_range(0, 9) == 0) begin
          base = $urandom_range(40, 1020);   // non-indexed strip
          write_vertex(base, pick_coord(), pick_coord(), pick_coord());
          write_vertex(base + 1, pick_coord(), pick_coord(), pick_coord());
          write_vertex(base + 2, pick_coord(), pick_coord(), pick_coord());
          add_triangle(base, base + 1, base + 2);
        end else if ($urandom_range(0, 9) == 0) begin
          base = pick_written();
          add_triangle(base, pick_written(), base);
        end else begin
          add_triangle(pick_written(), pick_written(), pick_written());
        end
      end else if (op < 95) begin
        read_normal($urandom_range(0, 7) == 0 ? $urandom_range(0, 1023) : pick_written());
      end else begin
        send_command(2'd3, $urandom_range(0, 1023), $urandom_range(0, 1023),
                     $urandom_range(0, 1023), 16'($urandom), 16'($urandom),
                     16'($urandom));
      end
    end
    in_ch.valid <= 1'b0;

    while (sb.owed_normals.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0 && sb.owed_normals.size() == 0) begin
      $display("PASS vertex_normal_accumulator");
    end else begin
      $display("FAIL vertex_normal_accumulator");
    end
    $finish;
  end

endmodule
